FILE: design/signed_int_to_decimal_ascii_core_macros.svh
// Assertion macros used by the converter's top-level RTL file.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`ifndef SYNTH
// Clocked assertion that is switched off while reset is held.
`define S2D_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion that is checked in every cycle, reset included.
`define S2D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define S2D_ASSERT(lbl, clk, rstn, prop, msg)
`define S2D_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/s2d_pkg.sv
// Package of the signed integer to decimal text converter: sizes, codes and types.
package s2d_pkg;
    localparam int VALUE_WIDTH = 64;
    // Decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1).
    localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_W = 4 * NDIG;
    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int DIG_W = $clog2(NDIG + 1);

    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic dshift;
    } t_dab_ctrl;

    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } t_beat;
endpackage

FILE: design/s2d_dabble.sv
// Bit-serial shift-and-add-three binary to BCD converter with a digit shift for read-out.
module s2d_dabble (
    input  logic                           i_clk,
    input  s2d_pkg::t_dab_ctrl             i_ctrl,
    input  logic [s2d_pkg::VALUE_WIDTH-1:0] i_mag,
    output logic [3:0]                     o_top_digit
);
    import s2d_pkg::*;

    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BCD_W-1:0]       w_adj;

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_ctrl.load) begin
            n_bin = i_mag;
            n_bcd = '0;
        end else if (i_ctrl.conv) begin
            n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
            n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
        end else if (i_ctrl.dshift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];
endmodule

FILE: design/s2d_out.sv
// Output register stage of the converter's character stream.
module s2d_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  s2d_pkg::t_beat i_beat,
    output logic           o_room,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,  // [5:0] ascii_char, [7:6] zero
    output logic           o_m_tlast   // last_char
);
    import s2d_pkg::*;

    logic  r_valid, n_valid;
    t_beat r_beat;

    assign o_room = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_push) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_beat <= i_beat;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {2'b00, r_beat.ch};
    assign o_m_tlast  = r_beat.last;
endmodule

FILE: design/signed_int_to_decimal_ascii_core.sv
// Top level of the signed integer to decimal ASCII text converter.
// One beat in carries a signed VALUE_WIDTH-bit integer in the low bits of
// i_s_tdata (higher bits are ignored). The block answers with its decimal
// text, one character per output beat, most significant first: a leading
// '-' for negative values, no leading zeros, a single '0' for zero, and
// tlast on the final character. The most negative value is converted
// exactly. One item is handled at a time: on acceptance the magnitude is
// formed and loaded, then the bit-serial shift-and-add-three loop runs
// over all VALUE_WIDTH bits to build the BCD digits, then leading zeros
// are skipped, and then the characters are sent, an optional minus sign
// first. The next item is taken as soon as the final character has
// entered the output register, even while that character still waits
// to be taken.
`include "signed_int_to_decimal_ascii_core_macros.svh"
module signed_int_to_decimal_ascii_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [5:0] ascii_char, [7:6] zero
    output logic        o_m_tlast    // last_char
);
    import s2d_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_bitcnt, n_bitcnt;
    logic [DIG_W-1:0]   r_digcnt, n_digcnt;
    logic               r_neg, n_neg;

    logic [VALUE_WIDTH-1:0] w_raw;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_accept;
    logic                   w_room;
    logic                   w_push;
    logic [3:0]             w_top;
    t_beat                  w_beat;
    t_dab_ctrl              w_ctrl;

    // Only the low VALUE_WIDTH bits count; the magnitude of a negative
    // value is its two's complement, which also covers the most negative
    // value since it is read back as an unsigned number.
    assign w_raw    = i_s_tdata[VALUE_WIDTH-1:0];
    assign w_mag    = w_raw[VALUE_WIDTH-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bitcnt <= n_bitcnt;
        r_digcnt <= n_digcnt;
        r_neg    <= n_neg;
    end

    // Sequencer: conversion, leading-zero skip, sign, then the digits.
    always_comb begin
        n_state     = r_state;
        n_bitcnt    = r_bitcnt;
        n_digcnt    = r_digcnt;
        n_neg       = r_neg;
        w_ctrl      = '0;
        w_push      = 1'b0;
        w_beat.ch   = CHAR_ZERO + {2'b00, w_top};
        w_beat.last = (r_digcnt == DIG_W'(1));
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctrl.load = 1'b1;
                    n_neg       = w_raw[VALUE_WIDTH-1];
                    n_bitcnt    = CNT_W'(VALUE_WIDTH - 1);
                    n_digcnt    = DIG_W'(NDIG);
                    n_state     = ST_CONV;
                end
            end
            ST_CONV: begin
                w_ctrl.conv = 1'b1;
                n_bitcnt    = r_bitcnt - 1'b1;
                if (r_bitcnt == '0) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros, but always keep the units digit.
                if (w_top == 4'd0 && r_digcnt != DIG_W'(1)) begin
                    w_ctrl.dshift = 1'b1;
                    n_digcnt      = r_digcnt - 1'b1;
                end else if (r_neg) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_SIGN: begin
                w_beat.ch   = CHAR_MINUS;
                w_beat.last = 1'b0;
                if (w_room) begin
                    w_push  = 1'b1;
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (w_room) begin
                    w_push        = 1'b1;
                    w_ctrl.dshift = 1'b1;
                    n_digcnt      = r_digcnt - 1'b1;
                    if (r_digcnt == DIG_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    s2d_dabble u_dabble (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_mag       (w_mag),
        .o_top_digit (w_top)
    );

    s2d_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_beat     (w_beat),
        .o_room     (w_room),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    `S2D_ASSERT(a_accept_starts_conv, i_clk, i_rst_n, w_accept |=> r_state == ST_CONV, "accepted item did not start conversion")
    `S2D_ASSERT(a_digit_count_live, i_clk, i_rst_n, (r_state == ST_DIGIT || r_state == ST_SIGN) |-> r_digcnt != '0, "no digits left while sending")
    `S2D_ASSERT(a_minus_not_last, i_clk, i_rst_n, (o_m_tvalid && o_m_tdata[5:0] == CHAR_MINUS) |-> !o_m_tlast, "minus sign flagged as last character")
    `S2D_ASSERT(a_digit_is_decimal, i_clk, i_rst_n, (w_push && r_state == ST_DIGIT) |-> w_top <= 4'd9, "BCD digit out of range")
endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the signed integer to decimal ASCII text converter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import s2d_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 120;
    localparam int LONG_HOLD   = 600;
    localparam int RANDOM_NUMS = 81;

    // One integer waiting to be offered, and whether the sender must first let
    // every outstanding character drain.
    typedef struct {
        logic [63:0] value;
        bit          drain_first;
    } t_number_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;   // [63:0] value
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;        // [5:0] ascii_char, [7:6] zero
    logic        o_m_tlast;        // last_char

    t_number_req number_reqs [$];
    t_beat       text_due [$];
    int          total_items = 1000;
    int          items_sent = 0;
    int          send_gap = 0;
    int          hold_left = 0;
    bit          long_hold_done = 1'b0;
    int          fault_count = 0;
    int          reset_cycles = 0;
    int          cycle_count = 0;
    logic        quiet;

    signed_int_to_decimal_ascii_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // No idling in the last stretch of the run, nor in one stretch mid-way.
    assign quiet = (items_sent >= total_items - 15) || (items_sent >= 50 && items_sent < 62);

    // Reset held low at the start, plus the overall cycle limit.
    always @(posedge i_clk) begin
        if (reset_cycles < 8) begin
            reset_cycles <= reset_cycles + 1;
        end
        i_rst_n <= (reset_cycles >= 7);
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Appends the expected characters of one accepted integer: an optional
    // minus sign, then the digits of the magnitude, most significant first.
    function automatic void queue_decimal_text(input logic [63:0] word);
        logic [63:0] width_mask;
        logic [63:0] raw;
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digit [$];
        t_beat       beat;
        width_mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
        raw = word & width_mask;
        neg = raw[VALUE_WIDTH-1];
        // The negation is done on 64 unsigned bits, so the most negative value
        // gives its true magnitude.
        mag = neg ? (64'd0 - (raw | ~width_mask)) : raw;
        do begin
            digit.push_front(4'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 0);
        if (neg) begin
            beat.ch = CHAR_MINUS;
            beat.last = 1'b0;
            text_due.push_back(beat);
        end
        foreach (digit[i]) begin
            beat.ch = CHAR_ZERO + 6'(digit[i]);
            beat.last = (i == digit.size() - 1);
            text_due.push_back(beat);
        end
    endfunction

    function automatic void note_fault(input string what);
        fault_count++;
        if (fault_count <= 10) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endfunction

    function automatic void add_number(input logic [63:0] value, input bit drain_first);
        t_number_req req;
        req.value = value;
        req.drain_first = drain_first;
        number_reqs.push_back(req);
    endfunction

    // Input side: holds each beat until it is taken, then predicts its text.
    always @(posedge i_clk) begin : sender
        logic        taken;
        logic        offer;
        t_number_req req;
        taken = i_s_tvalid && o_s_tready;
        offer = i_s_tvalid && !taken;
        if (!i_rst_n) begin
            offer = 1'b0;
        end else begin
            if (taken) begin
                queue_decimal_text(i_s_tdata);
                items_sent <= items_sent + 1;
                if (!quiet && $urandom_range(0, 2) == 0) begin
                    send_gap = $urandom_range(1, 9);
                end
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (number_reqs.size() > 0 &&
                             !(number_reqs[0].drain_first && text_due.size() != 0)) begin
                    req = number_reqs.pop_front();
                    i_s_tdata <= req.value;
                    offer = 1'b1;
                end
            end
        end
        i_s_tvalid <= offer;
    end

    // Output side: checks each character beat and decides when to stall.
    always @(posedge i_clk) begin : receiver
        t_beat want;
        logic  ready;
        ready = 1'b0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (text_due.size() == 0) begin
                    note_fault($sformatf("unexpected beat tdata=%0d tlast=%0b",
                                         o_m_tdata, o_m_tlast));
                end else begin
                    want = text_due.pop_front();
                    if (o_m_tdata !== {2'b00, want.ch} || o_m_tlast !== want.last) begin
                        note_fault($sformatf("expected tdata=%0d tlast=%0b, got tdata=%0d tlast=%0b",
                                             want.ch, want.last, o_m_tdata, o_m_tlast));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!long_hold_done && items_sent >= 30) begin
                // A long hold-off fills the block so that it stalls its input.
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                hold_left = $urandom_range(1, 9) - 1;
            end else begin
                ready = 1'b1;
            end
        end
        i_m_tready <= ready;
    end

    initial begin : stimulus
        logic [63:0] value;
        int          ndig;
        // Zero, single digits, digit-count boundaries and both extremes.
        add_number(64'd0, 1'b0);
        add_number(64'd1, 1'b0);
        add_number(-64'sd1, 1'b0);
        add_number(64'd9, 1'b0);
        add_number(64'd10, 1'b0);
        add_number(-64'sd10, 1'b0);
        add_number(64'd99, 1'b0);
        add_number(64'd100, 1'b0);
        add_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        add_number(64'h8000_0000_0000_0000, 1'b0);
        add_number(64'h8000_0000_0000_0001, 1'b0);
        add_number(64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
        add_number(64'd1000000000000000000, 1'b0);
        add_number(-64'sd999999999999999999, 1'b0);
        add_number(64'd1234567890, 1'b0);
        add_number(-64'sd1234567890123456789, 1'b0);
        add_number(-64'sd2, 1'b0);
        add_number(64'h5555_5555_5555_5555, 1'b0);
        add_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        for (int n = 0; n < RANDOM_NUMS; n++) begin
            case ($urandom_range(0, 3))
                0: value = {$urandom, $urandom};
                1: begin
                    ndig = $urandom_range(1, 19);
                    value = '0;
                    repeat (ndig) value = value * 64'd10 + 64'($urandom_range(0, 9));
                end
                2: begin
                    // Powers of ten and their neighbours.
                    value = 64'd1;
                    repeat ($urandom_range(0, 18)) value = value * 64'd10;
                    value = value - 64'd1 + 64'($urandom_range(0, 2));
                end
                default: value = 64'($urandom_range(0, 200));
            endcase
            if ($urandom_range(0, 1) == 1) begin
                value = 64'd0 - value;
            end
            // The sender waits for a full drain before two of the random items.
            add_number(value, n == 0 || n == 60);
        end
        total_items = number_reqs.size();

        while (number_reqs.size() != 0 || i_s_tvalid || text_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && text_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
